// ===== hdl/cfs_pkg.sv =====
// Shared types and constants for the Cholesky factor solve unit.
// Used by cfs_fpu and cholesky_factor_solve_unit; depends on nothing else.
package cfs_pkg;

  localparam int unsigned MaxSize = 16;
  localparam int unsigned IdxW    = $clog2(MaxSize);
  localparam int unsigned CntW    = IdxW + 1;
  localparam int unsigned FacAw   = 2 * IdxW;

  localparam logic RegSystemSize = 1'b0;

  localparam logic [63:0] DefaultNan = 64'hFFF8_0000_0000_0000;
  localparam logic [63:0] QuietBit   = 64'h0008_0000_0000_0000;
  localparam logic [10:0] ExpMax     = 11'h7FF;

  typedef enum logic [1:0] {
    CMD_LOAD_FACTOR = 2'd0,
    CMD_LOAD_RHS    = 2'd1,
    CMD_SOLVE       = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    FOP_MUL = 2'd0,
    FOP_SUB = 2'd1,
    FOP_DIV = 2'd2
  } fop_e;

  typedef struct packed {
    logic        start;
    fop_e        op;
    logic [63:0] a;
    logic [63:0] b;
  } fpu_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] result;
  } fpu_rsp_t;

  typedef enum logic [2:0] {
    FS_IDLE, FS_PRE, FS_MUL, FS_SUB, FS_DIV, FS_NORM, FS_DEN, FS_RND
  } fpu_state_e;

  typedef enum logic [3:0] {
    SQ_IDLE, SQ_ROW, SQ_ROW_W, SQ_INNER, SQ_MUL_GO, SQ_MUL_WAIT, SQ_SUB_WAIT,
    SQ_DIV_WAIT, SQ_WB, SQ_EMIT_RD, SQ_EMIT_W
  } seq_state_e;

endpackage

// ===== hdl/cholesky_factor_solve_unit.sv =====
// Top level of the Cholesky factor solve unit: stores, sequencer and APB register.
// Depends on cfs_pkg and cfs_fpu.
//
// Use: the input channel carries one beat per command. A factor beat writes
// L[row][column] (ignored above the diagonal), a right-hand beat writes g[row];
// both leave the unit idle, so loads stream at one beat per clock outside a solve. A solve
// beat computes s = -(L L^T)^-1 g for n = system_size unknowns (capped at 16)
// and sends n beats on the output channel, index 0 first, last_element on the
// final one. A solve with n of zero and the unused command produce nothing.
// The single shared floating point unit sets the solve time: every product,
// subtraction and row division runs on it in turn, and a subnormal operand, a deep
// cancellation or a subnormal result lengthens that operation. in_ready_o is low
// for the whole solve and its output phase.
// A result beat waits in an output register; while the receiver stalls the
// sequencer holds, and a new command is accepted as soon as the final beat has
// been loaded into that register.
// Reset returns system_size to 16 and empties the output register; the stores need no
// clearing, as a solve writes each work entry before reading it; the user must load each
// factor and right-hand entry a solve reads, which the unit does not enforce. system_size
// is written over APB at byte address 0 and should only change while the unit is idle.
module cholesky_factor_solve_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 command_i,
  input  logic [3:0]                 row_i,
  input  logic [3:0]                 column_i,
  input  logic [63:0]                element_bits_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [3:0]                 result_index_o,
  output logic [63:0]                result_bits_o,
  output logic                       last_element_o
);

  localparam int unsigned IdxW = cfs_pkg::IdxW;
  localparam int unsigned CntW = cfs_pkg::CntW;

  // Configuration register.
  logic [4:0] size_q;
  logic       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == cfs_pkg::RegSystemSize);
  assign prdata = (paddr[2] == cfs_pkg::RegSystemSize) ? {27'd0, size_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= 5'd16;
    end else if (cfg_we) begin
      size_q <= pwdata[4:0];
    end
  end

  // Sequencer state.
  cfs_pkg::seq_state_e state_q, state_d;
  logic [IdxW-1:0]     i_q, i_d;
  logic [CntW-1:0]     j_q, j_d, n_q, n_d;
  logic                bwd_q, bwd_d;
  logic [63:0]         acc_q, acc_d, diag_q, diag_d;
  logic                out_valid_q, out_valid_d, out_last_q, out_last_d;
  logic [IdxW-1:0]     out_idx_q, out_idx_d;
  logic [63:0]         out_bits_q, out_bits_d;

  // Stores: factor, right-hand side and work vector, each with a registered read.
  logic [63:0]              fac_mem [cfs_pkg::MaxSize * cfs_pkg::MaxSize];
  logic [63:0]              rhs_mem [cfs_pkg::MaxSize];
  logic [63:0]              wrk_mem [cfs_pkg::MaxSize];
  logic                     fac_we, fac_re, rhs_we, rhs_re, wrk_we, wrk_re;
  logic [cfs_pkg::FacAw-1:0] fac_wa, fac_ra;
  logic [IdxW-1:0]          rhs_ra, wrk_ra;
  logic [63:0]              fac_rd_q, rhs_rd_q, wrk_rd_q;

  always_ff @(posedge clk_i) begin
    if (fac_we) fac_mem[fac_wa] <= element_bits_i;
    if (fac_re) fac_rd_q <= fac_mem[fac_ra];
  end

  always_ff @(posedge clk_i) begin
    if (rhs_we) rhs_mem[row_i] <= element_bits_i;
    if (rhs_re) rhs_rd_q <= rhs_mem[rhs_ra];
  end

  always_ff @(posedge clk_i) begin
    if (wrk_we) wrk_mem[i_q] <= acc_q;
    if (wrk_re) wrk_rd_q <= wrk_mem[wrk_ra];
  end

  cfs_pkg::fpu_req_t fpu_req;
  cfs_pkg::fpu_rsp_t fpu_rsp;

  cfs_fpu u_fpu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (fpu_req),
    .rsp_o  (fpu_rsp)
  );

  logic in_acc, row_last, inner_more;

  assign in_ready_o = (state_q == cfs_pkg::SQ_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign row_last   = ({1'b0, i_q} == (n_q - {{(CntW-1){1'b0}}, 1'b1}));
  // Forward rows take columns below the diagonal; backward rows take the rows below it.
  assign inner_more = bwd_q ? (j_q < n_q) : (j_q < {1'b0, i_q});

  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    j_d         = j_q;
    n_d         = n_q;
    bwd_d       = bwd_q;
    acc_d       = acc_q;
    diag_d      = diag_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_idx_d   = out_idx_q;
    out_bits_d  = out_bits_q;
    out_last_d  = out_last_q;
    fac_we      = 1'b0;
    fac_re      = 1'b0;
    rhs_we      = 1'b0;
    rhs_re      = 1'b0;
    wrk_we      = 1'b0;
    wrk_re      = 1'b0;
    fac_wa      = {row_i, column_i};
    fac_ra      = {i_q, i_q};
    rhs_ra      = i_q;
    wrk_ra      = i_q;
    fpu_req     = '{start: 1'b0, op: cfs_pkg::FOP_MUL, a: fac_rd_q, b: wrk_rd_q};

    unique case (state_q)
      cfs_pkg::SQ_IDLE: begin
        if (in_acc) begin
          unique case (command_i)
            cfs_pkg::CMD_LOAD_FACTOR: fac_we = (column_i <= row_i);
            cfs_pkg::CMD_LOAD_RHS:    rhs_we = 1'b1;
            cfs_pkg::CMD_SOLVE: begin
              n_d   = (size_q > CntW'(cfs_pkg::MaxSize)) ? CntW'(cfs_pkg::MaxSize)
                                                          : size_q[CntW-1:0];
              i_d   = '0;
              bwd_d = 1'b0;
              if (n_d != '0) state_d = cfs_pkg::SQ_ROW;
            end
            default: ;
          endcase
        end
      end
      cfs_pkg::SQ_ROW: begin
        // Fetch the row's starting value and its diagonal entry.
        fac_re  = 1'b1;
        rhs_re  = 1'b1;
        wrk_re  = 1'b1;
        state_d = cfs_pkg::SQ_ROW_W;
      end
      cfs_pkg::SQ_ROW_W: begin
        acc_d   = bwd_q ? wrk_rd_q : rhs_rd_q;
        diag_d  = fac_rd_q;
        j_d     = bwd_q ? ({1'b0, i_q} + {{(CntW-1){1'b0}}, 1'b1}) : '0;
        state_d = cfs_pkg::SQ_INNER;
      end
      cfs_pkg::SQ_INNER: begin
        if (inner_more) begin
          fac_re  = 1'b1;
          fac_ra  = bwd_q ? {j_q[IdxW-1:0], i_q} : {i_q, j_q[IdxW-1:0]};
          wrk_re  = 1'b1;
          wrk_ra  = j_q[IdxW-1:0];
          state_d = cfs_pkg::SQ_MUL_GO;
        end else if (diag_q[62:0] != '0) begin
          fpu_req = '{start: 1'b1, op: cfs_pkg::FOP_DIV, a: acc_q, b: diag_q};
          state_d = cfs_pkg::SQ_DIV_WAIT;
        end else begin
          state_d = cfs_pkg::SQ_WB;
        end
      end
      cfs_pkg::SQ_MUL_GO: begin
        fpu_req = '{start: 1'b1, op: cfs_pkg::FOP_MUL, a: fac_rd_q, b: wrk_rd_q};
        state_d = cfs_pkg::SQ_MUL_WAIT;
      end
      cfs_pkg::SQ_MUL_WAIT: begin
        if (fpu_rsp.done) begin
          fpu_req = '{start: 1'b1, op: cfs_pkg::FOP_SUB, a: acc_q, b: fpu_rsp.result};
          state_d = cfs_pkg::SQ_SUB_WAIT;
        end
      end
      cfs_pkg::SQ_SUB_WAIT: begin
        if (fpu_rsp.done) begin
          acc_d   = fpu_rsp.result;
          j_d     = j_q + {{(CntW-1){1'b0}}, 1'b1};
          state_d = cfs_pkg::SQ_INNER;
        end
      end
      cfs_pkg::SQ_DIV_WAIT: begin
        if (fpu_rsp.done) begin
          acc_d   = fpu_rsp.result;
          state_d = cfs_pkg::SQ_WB;
        end
      end
      cfs_pkg::SQ_WB: begin
        wrk_we = 1'b1;
        if (!bwd_q) begin
          if (row_last) bwd_d = 1'b1;
          else i_d = i_q + {{(IdxW-1){1'b0}}, 1'b1};
          state_d = cfs_pkg::SQ_ROW;
        end else if (i_q == '0) begin
          state_d = cfs_pkg::SQ_EMIT_RD;
        end else begin
          i_d     = i_q - {{(IdxW-1){1'b0}}, 1'b1};
          state_d = cfs_pkg::SQ_ROW;
        end
      end
      cfs_pkg::SQ_EMIT_RD: begin
        wrk_re  = 1'b1;
        state_d = cfs_pkg::SQ_EMIT_W;
      end
      cfs_pkg::SQ_EMIT_W: begin
        // The read data register holds until the output register frees up.
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_idx_d   = i_q;
          out_bits_d  = {~wrk_rd_q[63], wrk_rd_q[62:0]};
          out_last_d  = row_last;
          if (row_last) begin
            state_d = cfs_pkg::SQ_IDLE;
          end else begin
            i_d     = i_q + {{(IdxW-1){1'b0}}, 1'b1};
            state_d = cfs_pkg::SQ_EMIT_RD;
          end
        end
      end
      default: state_d = cfs_pkg::SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cfs_pkg::SQ_IDLE;
      out_valid_q <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      n_q         <= '0;
      bwd_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      i_q         <= i_d;
      j_q         <= j_d;
      n_q         <= n_d;
      bwd_q       <= bwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    diag_q     <= diag_d;
    out_idx_q  <= out_idx_d;
    out_bits_q <= out_bits_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign result_index_o = out_idx_q;
  assign result_bits_o  = out_bits_q;
  assign last_element_o = out_last_q;

endmodule

// ===== hdl/cfs_fpu.sv =====
// Iterative double precision multiply, subtract and divide unit with
// round-to-nearest-even. Depends on cfs_pkg.
module cfs_fpu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfs_pkg::fpu_req_t req_i,
  output cfs_pkg::fpu_rsp_t rsp_o
);

  cfs_pkg::fpu_state_e state_q, state_d;
  cfs_pkg::fop_e       op_q, op_d;
  logic                sa_q, sa_d, sb_q, sb_d, sgn_q, sgn_d, stk_q, stk_d;
  logic signed [12:0]  ea_q, ea_d, eb_q, eb_d, exp_q, exp_d;
  logic [52:0]         ma_q, ma_d, mb_q, mb_d;
  logic [105:0]        acc_q, acc_d;
  logic [53:0]         rem_q, rem_d;
  logic [63:0]         mant_q, mant_d;
  logic [5:0]          cnt_q, cnt_d;
  logic [63:0]         res_q, res_d;
  logic                done_q, done_d;

  // Operand classification and the results that need no arithmetic.
  logic [10:0] a_ef, b_ef;
  logic [51:0] a_fr, b_fr;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sx, spec;
  logic [63:0] spec_res;

  always_comb begin
    a_ef   = req_i.a[62:52];
    b_ef   = req_i.b[62:52];
    a_fr   = req_i.a[51:0];
    b_fr   = req_i.b[51:0];
    a_nan  = (a_ef == cfs_pkg::ExpMax) && (a_fr != '0);
    b_nan  = (b_ef == cfs_pkg::ExpMax) && (b_fr != '0);
    a_inf  = (a_ef == cfs_pkg::ExpMax) && (a_fr == '0);
    b_inf  = (b_ef == cfs_pkg::ExpMax) && (b_fr == '0);
    a_zero = (a_ef == '0) && (a_fr == '0);
    b_zero = (b_ef == '0) && (b_fr == '0);
    sx     = req_i.a[63] ^ req_i.b[63];
    spec     = 1'b1;
    spec_res = '0;
    if (a_nan) begin
      spec_res = req_i.a | cfs_pkg::QuietBit;
    end else if (b_nan) begin
      spec_res = req_i.b | cfs_pkg::QuietBit;
    end else begin
      unique case (req_i.op)
        cfs_pkg::FOP_MUL: begin
          if ((a_inf && b_zero) || (a_zero && b_inf)) spec_res = cfs_pkg::DefaultNan;
          else if (a_inf || b_inf) spec_res = {sx, cfs_pkg::ExpMax, 52'd0};
          else if (a_zero || b_zero) spec_res = {sx, 63'd0};
          else spec = 1'b0;
        end
        cfs_pkg::FOP_SUB: begin
          if (a_inf && b_inf && (req_i.a[63] == req_i.b[63]))
            spec_res = cfs_pkg::DefaultNan;
          else if (a_inf) spec_res = req_i.a;
          else if (b_inf) spec_res = {~req_i.b[63], req_i.b[62:0]};
          else if (a_zero && b_zero) spec_res = {req_i.a[63] & ~req_i.b[63], 63'd0};
          else if (a_zero) spec_res = {~req_i.b[63], req_i.b[62:0]};
          else if (b_zero) spec_res = req_i.a;
          else spec = 1'b0;
        end
        cfs_pkg::FOP_DIV: begin
          if ((a_inf && b_inf) || (a_zero && b_zero)) spec_res = cfs_pkg::DefaultNan;
          else if (a_inf || b_zero) spec_res = {sx, cfs_pkg::ExpMax, 52'd0};
          else if (a_zero || b_inf) spec_res = {sx, 63'd0};
          else spec = 1'b0;
        end
        default: spec_res = cfs_pkg::DefaultNan;
      endcase
    end
  end

  // Datapath helpers for the individual steps.
  logic [60:0]        pp;
  logic [105:0]       psum;
  logic               a_big;
  logic [52:0]        big_s, sml_s;
  logic signed [12:0] e_big, e_sml, dd;
  logic [63:0]        big64, sml64, sh64, lost, rr;
  logic               ge;
  logic [53:0]        rem_n;
  logic [52:0]        keep;
  logic               rnd, st, inc;
  logic [53:0]        rsum;
  logic signed [12:0] e_out;
  logic [51:0]        frac;

  always_comb begin
    pp    = {8'd0, ma_q} * {53'd0, mb_q[7:0]};
    psum  = acc_q + ({45'd0, pp} << {cnt_q[2:0], 3'b000});

    a_big = (ea_q > eb_q) || ((ea_q == eb_q) && (ma_q >= mb_q));
    big_s = a_big ? ma_q : mb_q;
    sml_s = a_big ? mb_q : ma_q;
    e_big = a_big ? ea_q : eb_q;
    e_sml = a_big ? eb_q : ea_q;
    dd    = e_big - e_sml;
    big64 = {1'b0, big_s, 10'd0};
    sml64 = {1'b0, sml_s, 10'd0};
    if (dd[12:6] != '0) begin
      sh64 = 64'd1;
      lost = '0;
    end else begin
      lost = sml64 & ((64'd1 << dd[5:0]) - 64'd1);
      sh64 = (sml64 >> dd[5:0]) | {63'd0, lost != '0};
    end
    rr = (sa_q != sb_q) ? big64 + sh64 : big64 - sh64;

    ge    = rem_q >= {1'b0, mb_q};
    rem_n = ge ? rem_q - {1'b0, mb_q} : rem_q;

    keep = mant_q[63:11];
    rnd  = mant_q[10];
    st   = (mant_q[9:0] != '0) || stk_q;
    inc  = rnd && (st || keep[0]);
    rsum = {1'b0, keep} + {53'd0, inc};
    if (rsum[53]) begin
      e_out = exp_q + 13'sd1;
      frac  = rsum[52:1];
    end else begin
      e_out = rsum[52] ? exp_q : 13'sd0;
      frac  = rsum[51:0];
    end
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    sa_d    = sa_q;
    sb_d    = sb_q;
    ea_d    = ea_q;
    eb_d    = eb_q;
    ma_d    = ma_q;
    mb_d    = mb_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    mant_d  = mant_q;
    stk_d   = stk_q;
    exp_d   = exp_q;
    sgn_d   = sgn_q;
    cnt_d   = cnt_q;
    res_d   = res_q;
    done_d  = 1'b0;
    unique case (state_q)
      cfs_pkg::FS_IDLE: begin
        if (req_i.start) begin
          if (spec) begin
            res_d  = spec_res;
            done_d = 1'b1;
          end else begin
            op_d    = req_i.op;
            sa_d    = req_i.a[63];
            sb_d    = req_i.b[63];
            ea_d    = (a_ef == '0) ? -13'sd1022 : $signed({2'b00, a_ef}) - 13'sd1023;
            eb_d    = (b_ef == '0) ? -13'sd1022 : $signed({2'b00, b_ef}) - 13'sd1023;
            ma_d    = {a_ef != '0, a_fr};
            mb_d    = {b_ef != '0, b_fr};
            state_d = cfs_pkg::FS_PRE;
          end
        end
      end
      cfs_pkg::FS_PRE: begin
        if (!ma_q[52]) begin
          ma_d = {ma_q[51:0], 1'b0};
          ea_d = ea_q - 13'sd1;
        end
        if (!mb_q[52]) begin
          mb_d = {mb_q[51:0], 1'b0};
          eb_d = eb_q - 13'sd1;
        end
        if (ma_q[52] && mb_q[52]) begin
          cnt_d = '0;
          acc_d = '0;
          rem_d = {1'b0, ma_q};
          unique case (op_q)
            cfs_pkg::FOP_MUL: state_d = cfs_pkg::FS_MUL;
            cfs_pkg::FOP_SUB: state_d = cfs_pkg::FS_SUB;
            default:          state_d = cfs_pkg::FS_DIV;
          endcase
        end
      end
      cfs_pkg::FS_MUL: begin
        // Eight bits of the multiplier per cycle.
        acc_d = psum;
        mb_d  = {8'd0, mb_q[52:8]};
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd6) begin
          mant_d  = psum[105:42];
          stk_d   = psum[41:0] != '0;
          exp_d   = ea_q + eb_q + 13'sd1;
          sgn_d   = sa_q ^ sb_q;
          state_d = cfs_pkg::FS_NORM;
        end
      end
      cfs_pkg::FS_SUB: begin
        if (rr == '0) begin
          res_d   = '0;
          done_d  = 1'b1;
          state_d = cfs_pkg::FS_IDLE;
        end else begin
          mant_d  = rr;
          stk_d   = 1'b0;
          exp_d   = e_big + 13'sd1;
          sgn_d   = a_big ? sa_q : ~sb_q;
          state_d = cfs_pkg::FS_NORM;
        end
      end
      cfs_pkg::FS_DIV: begin
        // Restoring division, one quotient bit per cycle.
        mant_d = {mant_q[62:0], ge};
        rem_d  = {rem_n[52:0], 1'b0};
        cnt_d  = cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          stk_d   = rem_n != '0;
          exp_d   = ea_q - eb_q;
          sgn_d   = sa_q ^ sb_q;
          state_d = cfs_pkg::FS_NORM;
        end
      end
      cfs_pkg::FS_NORM: begin
        if (!mant_q[63]) begin
          mant_d = {mant_q[62:0], 1'b0};
          exp_d  = exp_q - 13'sd1;
        end else begin
          exp_d   = exp_q + 13'sd1023;
          state_d = cfs_pkg::FS_DEN;
        end
      end
      cfs_pkg::FS_DEN: begin
        // Results below the normal range are shifted down to subnormal form.
        if (exp_q < -13'sd64) begin
          stk_d  = stk_q || (mant_q != '0);
          mant_d = '0;
          exp_d  = 13'sd1;
        end else if (exp_q < 13'sd1) begin
          stk_d  = stk_q || mant_q[0];
          mant_d = {1'b0, mant_q[63:1]};
          exp_d  = exp_q + 13'sd1;
        end else begin
          state_d = cfs_pkg::FS_RND;
        end
      end
      cfs_pkg::FS_RND: begin
        if ((exp_q >= 13'sd2047) || (e_out >= 13'sd2047)) begin
          res_d = {sgn_q, cfs_pkg::ExpMax, 52'd0};
        end else begin
          res_d = {sgn_q, e_out[10:0], frac};
        end
        done_d  = 1'b1;
        state_d = cfs_pkg::FS_IDLE;
      end
      default: state_d = cfs_pkg::FS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cfs_pkg::FS_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    sa_q   <= sa_d;
    sb_q   <= sb_d;
    ea_q   <= ea_d;
    eb_q   <= eb_d;
    ma_q   <= ma_d;
    mb_q   <= mb_d;
    acc_q  <= acc_d;
    rem_q  <= rem_d;
    mant_q <= mant_d;
    stk_q  <= stk_d;
    exp_q  <= exp_d;
    sgn_q  <= sgn_d;
    cnt_q  <= cnt_d;
    res_q  <= res_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = res_q;

endmodule
